>>> sv/ascending_value_sorter_top_macros.svh
// Assertion macros used by the sorter controller.
`ifndef ASCENDING_VALUE_SORTER_TOP_MACROS_SVH
`define ASCENDING_VALUE_SORTER_TOP_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define AVS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define AVS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/avs_pkg.sv
// Package: sizes, cell link types, command types and states of the sorter.
package avs_pkg;

    localparam int MAX_ITEMS = 16;
    localparam int VALUE_W   = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [CNT_W-1:0]          count_t;

    // What one cell shows its neighbors
    typedef struct packed {
        logic   ins;
        logic   occ;
        value_t val;
    } cell_link_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic   insert;
        logic   drain;
        value_t value;
    } cell_cmd_t;

    typedef enum logic [0:0] {
        ST_LOAD  = 1'b0,
        ST_DRAIN = 1'b1
    } avs_state_t;

endpackage

>>> sv/avs_stream_ifs.sv
// Valid/ready stream interfaces for input items and sorted results.
interface avs_in_if;
    logic            valid;
    logic            ready;
    avs_pkg::value_t value;
    logic            end_of_list;

    modport source (output valid, output value, output end_of_list, input ready);
    modport sink   (input valid, input value, input end_of_list, output ready);
endinterface

interface avs_out_if;
    logic            valid;
    logic            ready;
    avs_pkg::value_t sorted_value;
    logic            last_out;
    logic            overflow;

    modport source (output valid, output sorted_value, output last_out, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_out, input overflow,
                    output ready);
endinterface

>>> sv/ascending_value_sorter_top.sv
// Sorter top level: a chain of insertion cells and its controller.
// Loading takes one input transaction per cycle; each value is placed in order on arrival.
// End of list sets the drain state, then the result register takes the first result; results
// drain one per cycle from the head cell while results.ready (N results for N held values).
// No new transaction is taken while a list drains; the next list loads right after.
// rst_n clears the fill count, overflow flag and cell occupancy at once; no clearing pass.
module ascending_value_sorter_top (
    input  logic      clk,
    input  logic      rst_n,
    avs_in_if.sink    items,
    avs_out_if.source results
);

    avs_pkg::cell_cmd_t  cmd;
    avs_pkg::cell_link_t links    [avs_pkg::MAX_ITEMS];
    avs_pkg::cell_link_t left_in  [avs_pkg::MAX_ITEMS];
    avs_pkg::cell_link_t right_in [avs_pkg::MAX_ITEMS];

    avs_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .head    (links[0]),
        .cmd     (cmd)
    );

    // Build the chain; the ends see an empty, non-inserting neighbor
    for (genvar i = 0; i < avs_pkg::MAX_ITEMS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign left_in[i] = '0;
        end
        else
        begin : g_mid_l
            assign left_in[i] = links[i-1];
        end

        if (i == avs_pkg::MAX_ITEMS - 1)
        begin : g_tail
            assign right_in[i] = '0;
        end
        else
        begin : g_mid_r
            assign right_in[i] = links[i+1];
        end

        avs_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .left  (left_in[i]),
            .right (right_in[i]),
            .link  (links[i])
        );
    end

endmodule

>>> sv/avs_cell.sv
// One sorting cell: holds a value, inserts in order, shifts toward the head on drain.
module avs_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  avs_pkg::cell_cmd_t  cmd,
    input  avs_pkg::cell_link_t left,
    input  avs_pkg::cell_link_t right,
    output avs_pkg::cell_link_t link
);

    logic            occ_reg;
    avs_pkg::value_t val_reg;
    logic            ins;

    // Insert point: empty cell, or new value strictly below the held one
    always_comb
    begin
        ins = !occ_reg || (cmd.value < val_reg);
    end

    assign link.ins = ins;
    assign link.occ = occ_reg;
    assign link.val = val_reg;

    // Occupancy: take the left neighbor on a shift, take the new value at the insert point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else if (cmd.insert)
        begin
            if (left.ins)
            begin
                occ_reg <= left.occ;
            end
            else if (ins)
            begin
                occ_reg <= 1'b1;
            end
        end
        else if (cmd.drain)
        begin
            occ_reg <= right.occ;
        end
    end

    // Held value follows the same moves
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            if (left.ins)
            begin
                val_reg <= left.val;
            end
            else if (ins)
            begin
                val_reg <= cmd.value;
            end
        end
        else if (cmd.drain)
        begin
            val_reg <= right.val;
        end
    end

endmodule

>>> sv/avs_ctrl.sv
// Controller: input handshake, fill count, overflow flag, drain sequencing, result register.
`include "ascending_value_sorter_top_macros.svh"

module avs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    avs_in_if.sink              items,
    avs_out_if.source           results,
    input  avs_pkg::cell_link_t head,
    output avs_pkg::cell_cmd_t  cmd
);

    avs_pkg::avs_state_t state_reg, state_next;
    avs_pkg::count_t     count_reg, count_next;
    logic                dropped_reg, dropped_next;
    logic                out_valid_reg, out_valid_next;
    avs_pkg::value_t     out_value_reg;
    logic                out_last_reg;
    logic                out_ovf_reg;

    logic accept;
    logic full;
    logic drain;

    assign full  = (count_reg == avs_pkg::count_t'(avs_pkg::MAX_ITEMS));

    // Next state, commands to the chain and result register control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        items.ready    = 1'b0;
        accept         = 1'b0;
        drain          = 1'b0;
        out_valid_next = out_valid_reg && !results.ready;
        case (state_reg)
            avs_pkg::ST_LOAD:
            begin
                items.ready = 1'b1;
                accept      = items.valid;
                if (accept)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + avs_pkg::count_t'(1);
                    end
                    if (items.end_of_list)
                    begin
                        state_next = avs_pkg::ST_DRAIN;
                    end
                end
            end
            avs_pkg::ST_DRAIN:
            begin
                drain = !out_valid_reg || results.ready;
                if (drain)
                begin
                    out_valid_next = 1'b1;
                    count_next     = count_reg - avs_pkg::count_t'(1);
                    if (count_reg == avs_pkg::count_t'(1))
                    begin
                        state_next   = avs_pkg::ST_LOAD;
                        dropped_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = avs_pkg::ST_LOAD;
            end
        endcase
    end

    assign cmd.insert = accept && !full;
    assign cmd.drain  = drain;
    assign cmd.value  = items.value;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= avs_pkg::ST_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the head of the chain as the next result
    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            out_value_reg <= head.val;
            out_last_reg  <= (count_reg == avs_pkg::count_t'(1));
            out_ovf_reg   <= dropped_reg;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.sorted_value = out_value_reg;
    assign results.last_out     = out_last_reg;
    assign results.overflow     = out_ovf_reg;

    `AVS_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= avs_pkg::count_t'(avs_pkg::MAX_ITEMS), "fill count above capacity")
    `AVS_ASSERT_SAME(a_drain_nonempty, state_reg == avs_pkg::ST_DRAIN, count_reg != '0 && head.occ, "drain with empty chain")
    `AVS_ASSERT_NEXT(a_last_ends_run, drain && count_reg == avs_pkg::count_t'(1), state_reg == avs_pkg::ST_LOAD && count_reg == '0 && !dropped_reg, "run did not end after last result")
    `AVS_ASSERT_SAME(a_no_insert_drain, cmd.drain, !cmd.insert && !items.ready, "insert during drain")

endmodule

>>> tb/ascending_value_sorter_top_test.sv
// Testbench for the ascending value sorter: directed and randomized lists checked against a sorting model.
`timescale 1ns / 1ps

module ascending_value_sorter_top_test;

    localparam int     CLK_PERIOD       = 20;
    localparam int     RESET_CYCLES     = 10;
    localparam int     LONG_HOLD_CYCLES = 300;
    localparam int     SETTLE_CYCLES    = 20;
    localparam int     CYCLE_LIMIT      = 200000;
    localparam int     PHASE_ITEMS      = 90;
    localparam avs_pkg::value_t VALUE_MIN = {1'b1, {(avs_pkg::VALUE_W-1){1'b0}}};
    localparam avs_pkg::value_t VALUE_MAX = {1'b0, {(avs_pkg::VALUE_W-1){1'b1}}};

    typedef struct {
        avs_pkg::value_t value;
        logic            end_of_list;
    } list_item_t;

    typedef struct {
        avs_pkg::value_t sorted_value;
        logic            last_out;
        logic            overflow;
    } sorted_result_t;

    logic clk = 1'b0;
    logic rst_n;

    avs_in_if  items_if ();
    avs_out_if results_if ();

    ascending_value_sorter_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if)
    );

    // Items waiting to be offered, and sorted results waiting to be seen
    list_item_t     pending_items[$];
    sorted_result_t sorted_run_q[$];

    // Predictor state: values of the current list kept in ascending order
    avs_pkg::value_t list_store[avs_pkg::MAX_ITEMS];
    int              list_count   = 0;
    logic            list_dropped = 1'b0;

    int   sender_idle_pct;
    int   recv_stall_pct;
    logic hold_request;
    logic long_hold;
    int   error_count;
    int   cycle_count;

    list_item_t     offered_item;
    sorted_result_t expected_result;

    always #(CLK_PERIOD/2) clk = ~clk;

    // Insert one accepted value in order; on end of list, emit the sorted run
    task automatic predict_sorted_run(input avs_pkg::value_t v, input logic eol);
        int             pos;
        sorted_result_t res;
        if (list_count < avs_pkg::MAX_ITEMS)
        begin
            pos = list_count;
            while (pos > 0 && list_store[pos-1] > v)
            begin
                list_store[pos] = list_store[pos-1];
                pos--;
            end
            list_store[pos] = v;
            list_count++;
        end
        else
        begin
            list_dropped = 1'b1;
        end
        if (eol)
        begin
            for (pos = 0; pos < list_count; pos++)
            begin
                res.sorted_value = list_store[pos];
                res.last_out     = (pos == list_count - 1);
                res.overflow     = list_dropped;
                sorted_run_q.push_back(res);
            end
            list_count   = 0;
            list_dropped = 1'b0;
        end
    endtask

    function automatic avs_pkg::value_t pick_value();
        avs_pkg::value_t v;
        case ($urandom_range(9))
            5, 6:
                v = avs_pkg::value_t'($urandom_range(6)) - avs_pkg::value_t'(3);
            7:
                case ($urandom_range(3))
                    0:       v = VALUE_MIN;
                    1:       v = VALUE_MAX;
                    2:       v = '0;
                    default: v = '1;
                endcase
            8:
                v = avs_pkg::value_t'($urandom_range(2000)) - avs_pkg::value_t'(1000);
            default:
                v = avs_pkg::value_t'($urandom);
        endcase
        return v;
    endfunction

    task automatic push_item(input avs_pkg::value_t v, input logic eol);
        list_item_t it;
        it.value       = v;
        it.end_of_list = eol;
        pending_items.push_back(it);
    endtask

    // Mostly short lists, some up to full, a few that overrun the store
    task automatic queue_random_lists(input int item_budget);
        int queued;
        int len;
        int k;
        queued = 0;
        while (queued < item_budget)
        begin
            case ($urandom_range(9))
                0:       len = $urandom_range(24, avs_pkg::MAX_ITEMS + 1);
                1, 2, 3: len = $urandom_range(avs_pkg::MAX_ITEMS, 7);
                default: len = $urandom_range(6, 1);
            endcase
            for (k = 0; k < len; k++)
                push_item(pick_value(), k == len - 1);
            queued += len;
        end
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(negedge clk);
        sender_idle_pct = send_pct;
        recv_stall_pct  = recv_pct;
    endtask

    // Wait until every queued item went in and every result came out
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || items_if.valid || sorted_run_q.size() != 0);
    endtask

    // Drive items: hold the current transaction until taken, then offer the next
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_if.valid       <= 1'b0;
            items_if.value       <= '0;
            items_if.end_of_list <= 1'b0;
        end
        else
        begin
            if (items_if.valid && items_if.ready)
                predict_sorted_run(items_if.value, items_if.end_of_list);
            if (!items_if.valid || items_if.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    offered_item = pending_items.pop_front();
                    items_if.valid       <= 1'b1;
                    items_if.value       <= offered_item.value;
                    items_if.end_of_list <= offered_item.end_of_list;
                end
                else
                begin
                    items_if.valid <= 1'b0;
                end
            end
        end
    end

    // Check each result transaction against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
        end
        else
        begin
            if (results_if.valid && results_if.ready)
            begin
                if (sorted_run_q.size() == 0)
                begin
                    $error("unexpected result: sorted_value %0d last_out %0b overflow %0b",
                           results_if.sorted_value, results_if.last_out, results_if.overflow);
                    error_count++;
                end
                else
                begin
                    expected_result = sorted_run_q.pop_front();
                    if (results_if.sorted_value !== expected_result.sorted_value)
                    begin
                        $error("sorted_value: expected %0d, got %0d",
                               expected_result.sorted_value, results_if.sorted_value);
                        error_count++;
                    end
                    if (results_if.last_out !== expected_result.last_out)
                    begin
                        $error("last_out: expected %0b, got %0b",
                               expected_result.last_out, results_if.last_out);
                        error_count++;
                    end
                    if (results_if.overflow !== expected_result.overflow)
                    begin
                        $error("overflow: expected %0b, got %0b",
                               expected_result.overflow, results_if.overflow);
                        error_count++;
                    end
                end
            end
            results_if.ready <= !long_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Hold off the receiver once for a long stretch
    initial
    begin
        long_hold = 1'b0;
        wait (hold_request);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Count cycles and stop a run that hangs
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("ascending_value_sorter_top_test: errors");
        $finish;
    end

    initial
    begin
        int k;
        hold_request         = 1'b0;
        sender_idle_pct      = 0;
        recv_stall_pct       = 0;
        rst_n                = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: single-value lists at both extremes
        push_item(VALUE_MAX, 1'b1);
        push_item(VALUE_MIN, 1'b1);
        // Extremes across the sign boundary, with repeated values
        push_item(avs_pkg::value_t'(7), 1'b0);
        push_item(VALUE_MIN, 1'b0);
        push_item(VALUE_MAX, 1'b0);
        push_item('0, 1'b0);
        push_item('1, 1'b0);
        push_item(avs_pkg::value_t'(7), 1'b1);
        // Descending list that fills the store; the end-of-list value is dropped
        for (k = 0; k <= avs_pkg::MAX_ITEMS; k++)
            push_item(avs_pkg::value_t'(8 - k), k == avs_pkg::MAX_ITEMS);
        wait_drained();

        // Random lists under each idling mix
        set_idling(0, 0);
        queue_random_lists(PHASE_ITEMS);
        wait_drained();
        set_idling(62, 0);
        queue_random_lists(PHASE_ITEMS);
        wait_drained();
        set_idling(0, 62);
        queue_random_lists(PHASE_ITEMS);
        wait_drained();
        set_idling(18, 18);
        queue_random_lists(PHASE_ITEMS);
        wait_drained();

        // Back-pressure: receiver held off while full lists keep coming
        set_idling(0, 0);
        hold_request = 1'b1;
        for (k = 0; k < 3 * avs_pkg::MAX_ITEMS; k++)
            push_item(pick_value(), (k % avs_pkg::MAX_ITEMS) == avs_pkg::MAX_ITEMS - 1);
        wait_drained();

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("ascending_value_sorter_top_test: clean");
        else
            $display("ascending_value_sorter_top_test: errors");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/avs_pkg.sv
sv/avs_stream_ifs.sv
sv/avs_cell.sv
sv/avs_ctrl.sv
sv/ascending_value_sorter_top.sv
tb/ascending_value_sorter_top_test.sv
